@@ rtl/stc_pkg.sv @@
// shared types, constants and helper functions for the spring torque compensation block
package stc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PITCH_X   = 3'd0;
    localparam logic [2:0] REG_PITCH_Z   = 3'd1;
    localparam logic [2:0] REG_YAW_X     = 3'd2;
    localparam logic [2:0] REG_YAW_Z     = 3'd3;
    localparam logic [2:0] REG_FREE_LEN  = 3'd4;
    localparam logic [2:0] REG_RATE      = 3'd5;
    localparam logic [2:0] REG_MOTOR_INV = 3'd6;

    localparam int ANGLE_W  = 16;
    localparam int COORD_W  = 32;
    localparam int RESULT_W = 32;

    // cordic gain in q2.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

    // step counts of the iterative units and datapath widths
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int LEN_W        = 34;
    localparam int TMAG_W       = 69;
    localparam int DMAG_W       = 35;
    localparam int NUM_W        = 105;
    localparam int Q_W          = 41;

    // folded angle handed from front to back
    typedef struct packed {
        logic        flip;
        logic [31:0] angle;
    } stc_item_t;

    // configuration register set
    typedef struct packed {
        logic [31:0] pitch_mount_x;
        logic [31:0] pitch_mount_z;
        logic [31:0] yaw_mount_x;
        logic [31:0] yaw_mount_z;
        logic [30:0] free_length;
        logic [30:0] spring_rate;
        logic        motor_inverted;
    } stc_cfg_t;

    // arctangent of 2^-i in 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0: a = 32'd536870912;
            5'd1: a = 32'd316933406;
            5'd2: a = 32'd167458907;
            5'd3: a = 32'd85004756;
            5'd4: a = 32'd42667331;
            5'd5: a = 32'd21354465;
            5'd6: a = 32'd10679838;
            5'd7: a = 32'd5340245;
            5'd8: a = 32'd2670163;
            5'd9: a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // sign and magnitude to saturated 32-bit two's complement
    function automatic logic [31:0] pack_sat(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        logic [63:0] m;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        m = (mag > lim) ? lim : mag;
        return neg ? 32'(64'd0 - m) : m[31:0];
    endfunction

endpackage

@@ rtl/spring_torque_compensation_core.sv @@
// Spring torque compensation: each pitch angle beat yields one beat with the
// saturated Q16.16 spring moment and the compensation effort. Angles enter a
// two-entry queue and are taken one at a time by the compute engine, which runs
// the 24-step cordic, the 32-step square root, the 35-step serial multiplier
// and the 105-step bit-serial divider; an item with a zero spring length skips
// the multiplier and the divider and yields a zero moment and effort.
// Results sit in an output register, so the engine moves on while a result
// waits. Configuration registers are written through the plain write port
// and should only change while no item is in flight.
module spring_torque_compensation_core #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] pitch_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [31:0] effort, [63:32] moment
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import stc_pkg::*;

    stc_cfg_t  cfg_reg;
    stc_item_t push_item;
    stc_item_t pop_item;
    logic      push_valid;
    logic      queue_full;
    logic      pop_valid;
    logic      pop_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PITCH_X:   cfg_reg.pitch_mount_x  <= cfg_wdata;
                REG_PITCH_Z:   cfg_reg.pitch_mount_z  <= cfg_wdata;
                REG_YAW_X:     cfg_reg.yaw_mount_x    <= cfg_wdata;
                REG_YAW_Z:     cfg_reg.yaw_mount_z    <= cfg_wdata;
                REG_FREE_LEN:  cfg_reg.free_length    <= cfg_wdata[30:0];
                REG_RATE:      cfg_reg.spring_rate    <= cfg_wdata[30:0];
                REG_MOTOR_INV: cfg_reg.motor_inverted <= cfg_wdata[0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    stc_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .queue_full (queue_full),
        .push_item  (push_item)
    );

    stc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    stc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item       (pop_item),
        .cfg        (cfg_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ rtl/stc_front.sv @@
// input side: angle quantization and folding into the cordic range
module stc_front #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,    // [15:0] pitch_angle
    output logic                       push_valid,
    input  logic                       queue_full,
    output stc_pkg::stc_item_t         push_item
);
    import stc_pkg::*;

    localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic [31:0] p_q;
    logic        flip;

    // keep the top angle bits, fold into +-1/4 turn
    always_comb begin
        p_q  = {s_tdata[ANGLE_W-1:0], 16'd0} & ANG_MASK;
        flip = p_q[31] ^ p_q[30];
        push_item.flip  = flip;
        push_item.angle = flip ? (p_q + 32'h8000_0000) : p_q;
    end

    assign s_tready   = ~queue_full;
    assign push_valid = s_tvalid;

endmodule

@@ rtl/stc_queue.sv @@
// two-entry queue between the front and the back
module stc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  stc_pkg::stc_item_t push_item,
    output logic               full,
    output logic               pop_valid,
    input  logic               pop_ready,
    output stc_pkg::stc_item_t pop_item
);
    import stc_pkg::*;

    stc_item_t   mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign push      = push_valid & ~full;
    assign pop       = pop_valid & pop_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ rtl/stc_back.sv @@
// compute engine: cordic, rotation, spring length, moment division and effort
module stc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    output logic               item_ready,
    input  stc_pkg::stc_item_t item,
    input  stc_pkg::stc_cfg_t  cfg,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata
);
    import stc_pkg::*;

    localparam int DEN_W     = LEN_W + FRAC_BITS;
    localparam int MUL_STEPS = DMAG_W;
    localparam int DIV_STEPS = NUM_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_ROT0, S_ROT1, S_ROT2, S_VEC, S_SQ, S_SQRT,
        S_LEN, S_MUL, S_RND, S_DIV, S_EFF0, S_EFF1, S_DONE
    } state_t;

    state_t               state_reg;
    logic [6:0]           step_reg;
    logic                 flip_reg;
    logic signed [33:0]   z_reg;
    logic signed [33:0]   cx_reg;
    logic signed [33:0]   cy_reg;
    logic signed [65:0]   pa_reg;
    logic signed [65:0]   pb_reg;
    logic signed [35:0]   px_reg;
    logic signed [35:0]   pz_reg;
    logic [31:0]          sa_reg;
    logic [31:0]          sb_reg;
    logic                 sh_reg;
    logic [63:0]          v_reg;
    logic [63:0]          r_reg;
    logic [63:0]          bit_reg;
    logic [67:0]          m1_reg;
    logic [67:0]          m2_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [TMAG_W-1:0]    tmag_reg;
    logic [DMAG_W-1:0]    dmag_reg;
    logic                 neg_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [Q_W-1:0]       q_reg;
    logic [62:0]          prod_reg;
    logic                 eneg_reg;
    logic [31:0]          moment_res_reg;
    logic [31:0]          effort_res_reg;
    logic                 ovalid_reg;
    logic [31:0]          effort_reg;
    logic [31:0]          moment_reg;

    logic signed [31:0]   mx;
    logic signed [31:0]   mz;
    logic signed [31:0]   yx;
    logic signed [31:0]   yz;
    logic signed [33:0]   dx;
    logic signed [33:0]   dy;
    logic signed [33:0]   at;
    logic signed [33:0]   cxf;
    logic signed [33:0]   cyf;
    logic signed [66:0]   rsum_x;
    logic signed [66:0]   rsum_z;
    logic signed [36:0]   vx;
    logic signed [36:0]   vz;
    logic [36:0]          ax;
    logic [36:0]          az;
    logic                 sh;
    logic [63:0]          trial;
    logic                 sq_ge;
    logic [LEN_W-1:0]     len_val;
    logic [35:0]          pzm;
    logic [35:0]          pxm;
    logic [31:0]          yxm;
    logic [31:0]          yzm;
    logic                 s1;
    logic                 s2;
    logic [TMAG_W-1:0]    tmag;
    logic                 tneg;
    logic signed [34:0]   dval;
    logic [DMAG_W-1:0]    dmag;
    logic [DEN_W-1:0]     den;
    logic [NUM_W-1:0]     acc_next;
    logic [DEN_W:0]       rem_sh;
    logic                 div_ge;
    logic [DEN_W:0]       rem_new;
    logic [Q_W:0]         q_sh;
    logic [Q_W-1:0]       q_new;
    logic                 mneg;
    logic [31:0]          mmag;
    logic [63:0]          emag;

    assign mx = $signed(cfg.pitch_mount_x);
    assign mz = $signed(cfg.pitch_mount_z);
    assign yx = $signed(cfg.yaw_mount_x);
    assign yz = $signed(cfg.yaw_mount_z);

    // cordic micro-rotation
    always_comb begin
        dx  = cy_reg >>> step_reg[4:0];
        dy  = cx_reg >>> step_reg[4:0];
        at  = $signed({2'b00, atan_turn(step_reg[4:0])});
        cxf = flip_reg ? -cx_reg : cx_reg;
        cyf = flip_reg ? -cy_reg : cy_reg;
    end

    // rotated point rounding, spring vector and its scaled magnitude
    always_comb begin
        rsum_x = 67'(pa_reg) - 67'(pb_reg) + (67'sd1 <<< 29);
        rsum_z = 67'(pa_reg) + 67'(pb_reg) + (67'sd1 <<< 29);
        vx = 37'(yx) - 37'(px_reg);
        vz = 37'(yz) - 37'(pz_reg);
        ax = vx[36] ? 37'(-vx) : 37'(vx);
        az = vz[36] ? 37'(-vz) : 37'(vz);
        sh = (ax >= 37'h0_8000_0000) || (az >= 37'h0_8000_0000);
    end

    // square root digit
    always_comb begin
        trial   = r_reg + bit_reg;
        sq_ge   = (v_reg >= trial);
        len_val = sh_reg ? (LEN_W'(r_reg) << 2) : LEN_W'(r_reg);
    end

    // cross term and stretch, both as sign and magnitude
    always_comb begin
        pzm = pz_reg[35] ? 36'(-pz_reg) : 36'(pz_reg);
        pxm = px_reg[35] ? 36'(-px_reg) : 36'(px_reg);
        yxm = yx[31] ? 32'(-yx) : 32'(yx);
        yzm = yz[31] ? 32'(-yz) : 32'(yz);
        s1  = pz_reg[35] ^ yx[31];
        s2  = ~(px_reg[35] ^ yz[31]);
        if (s1 == s2) begin
            tmag = TMAG_W'(m1_reg) + TMAG_W'(m2_reg);
            tneg = s1;
        end else if (m1_reg >= m2_reg) begin
            tmag = TMAG_W'(m1_reg - m2_reg);
            tneg = s1;
        end else begin
            tmag = TMAG_W'(m2_reg - m1_reg);
            tneg = s2;
        end
        dval = $signed({1'b0, len_val}) - $signed({4'b0000, cfg.free_length});
        dmag = dval[34] ? DMAG_W'(-dval) : DMAG_W'(dval);
    end

    // serial multiply and restoring divide steps
    always_comb begin
        den      = {len_reg, {FRAC_BITS{1'b0}}};
        acc_next = {num_reg[NUM_W-2:0], 1'b0}
                 + (dmag_reg[DMAG_W-1] ? NUM_W'(tmag_reg) : NUM_W'(0));
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        div_ge   = (rem_sh >= {1'b0, den});
        rem_new  = div_ge ? (rem_sh - {1'b0, den}) : rem_sh;
        q_sh     = {q_reg, div_ge};
        q_new    = (q_sh > (Q_W+1)'(1) << (Q_W-1)) ? Q_W'(1) << (Q_W-1) : q_sh[Q_W-1:0];
    end

    // moment sign and clamp, effort rounding
    always_comb begin
        mneg = neg_reg & (q_reg != '0);
        if (q_reg > (mneg ? Q_W'(33'h1_0000_0000 >> 1) : Q_W'(32'h7FFF_FFFF))) begin
            mmag = mneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            mmag = q_reg[31:0];
        end
        emag = (64'(prod_reg) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    end

    assign item_ready = (state_reg == S_IDLE);
    assign m_tvalid   = ovalid_reg;
    assign m_tdata    = {moment_reg, effort_reg};

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            // a taken beat leaves unless a new one replaces it
            if (m_tready && state_reg != S_DONE) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (item_valid) begin
                        z_reg     <= 34'($signed(item.angle));
                        flip_reg  <= item.flip;
                        cx_reg    <= CORDIC_GAIN;
                        cy_reg    <= '0;
                        step_reg  <= '0;
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (!z_reg[33]) begin
                        cx_reg <= cx_reg - dx;
                        cy_reg <= cy_reg + dy;
                        z_reg  <= z_reg - at;
                    end else begin
                        cx_reg <= cx_reg + dx;
                        cy_reg <= cy_reg - dy;
                        z_reg  <= z_reg + at;
                    end
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'(CORDIC_STEPS - 1)) begin
                        state_reg <= S_ROT0;
                    end
                end
                S_ROT0: begin
                    pa_reg    <= mx * cxf;
                    pb_reg    <= mz * cyf;
                    state_reg <= S_ROT1;
                end
                S_ROT1: begin
                    px_reg    <= 36'(rsum_x >>> 30);
                    pa_reg    <= mx * cyf;
                    pb_reg    <= mz * cxf;
                    state_reg <= S_ROT2;
                end
                S_ROT2: begin
                    pz_reg    <= 36'(rsum_z >>> 30);
                    state_reg <= S_VEC;
                end
                S_VEC: begin
                    sh_reg    <= sh;
                    sa_reg    <= sh ? 32'(ax >> 2) : 32'(ax);
                    sb_reg    <= sh ? 32'(az >> 2) : 32'(az);
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    v_reg     <= 64'(sa_reg) * 64'(sa_reg) + 64'(sb_reg) * 64'(sb_reg);
                    r_reg     <= '0;
                    bit_reg   <= 64'd1 << 62;
                    m1_reg    <= 68'(pzm) * 68'(yxm);
                    m2_reg    <= 68'(pxm) * 68'(yzm);
                    step_reg  <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        v_reg <= v_reg - trial;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'(SQRT_STEPS - 1)) begin
                        state_reg <= S_LEN;
                    end
                end
                S_LEN: begin
                    len_reg  <= len_val;
                    tmag_reg <= tmag;
                    dmag_reg <= dmag;
                    neg_reg  <= tneg ^ dval[34];
                    num_reg  <= '0;
                    step_reg <= '0;
                    if (len_val == '0) begin
                        moment_res_reg <= '0;
                        effort_res_reg <= '0;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    num_reg  <= acc_next;
                    dmag_reg <= {dmag_reg[DMAG_W-2:0], 1'b0};
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'(MUL_STEPS - 1)) begin
                        state_reg <= S_RND;
                    end
                end
                S_RND: begin
                    num_reg   <= num_reg + NUM_W'(den >> 1);
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg  <= rem_new[DEN_W-1:0];
                    q_reg    <= q_new;
                    num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'(DIV_STEPS - 1)) begin
                        state_reg <= S_EFF0;
                    end
                end
                S_EFF0: begin
                    moment_res_reg <= pack_sat(mneg, 64'(q_reg));
                    prod_reg       <= 63'(mmag) * 63'(cfg.spring_rate);
                    eneg_reg       <= mneg ^ ~cfg.motor_inverted;
                    state_reg      <= S_EFF1;
                end
                S_EFF1: begin
                    effort_res_reg <= pack_sat(eneg_reg & (emag != '0), emag);
                    state_reg      <= S_DONE;
                end
                S_DONE: begin
                    if (!ovalid_reg || m_tready) begin
                        ovalid_reg <= 1'b1;
                        effort_reg <= effort_res_reg;
                        moment_reg <= moment_res_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/stc_checker.sv @@
// port-level checks for the spring torque compensation block, bound to the top level
module stc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        cfg_wr_en,
    input logic [2:0]  cfg_index,
    input logic [31:0] cfg_wdata
);

    // a stalled result beat stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // a zero moment always gives a zero effort
    a_zero_moment: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[63:32] == 32'd0) |-> (m_tdata[31:0] == 32'd0))
        else $error("nonzero effort with zero moment");

endmodule

bind spring_torque_compensation_core stc_checker u_stc_checker (.*);

@@ dv/spring_torque_compensation_core_tb.sv @@
// testbench for the spring torque compensation core: table-driven and random pitch beats
`timescale 1ns / 1ps

module spring_torque_compensation_core_tb;
    import stc_pkg::*;

    localparam int FRAC = 16;
    localparam int ANGLE_KEEP = 16;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int ENGINE_CYCLES = 260;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    always #2 aclk = ~aclk;

    spring_torque_compensation_core u_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_index, .cfg_wdata
    );

    // torque result as it leaves the block
    typedef struct packed {
        logic [31:0] moment;
        logic [31:0] effort;
    } torque_t;

    // directed stimulus row
    typedef struct {
        logic [15:0] angle;
        logic        known;
        torque_t     torque;
    } angle_row_t;

    stc_cfg_t cfg_shadow;
    torque_t  torque_q[$];
    int       err_cnt = 0;
    int       cycle_cnt = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_off = 0;

    const logic [31:0] atan_tab[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(logic neg, logic [63:0] mag);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (mag > lim) mag = lim;
        return neg ? 32'(64'd0 - mag) : mag[31:0];
    endfunction

    // moment and effort for one pitch angle under the shadow settings
    function automatic torque_t spring_torque(logic [15:0] angle);
        logic [31:0] p;
        logic flip, tneg, neg, eneg;
        longint z, cx, cy, dx, dy, mx, mz, yx, yz, px, pz, d;
        logic [63:0] ax, az, len, m1, m2, tmag, dmag, den, mmag, emag;
        logic [127:0] num, q;
        logic s1, s2;
        int sh;
        torque_t t;
        p = {angle, 16'd0};
        p &= ~((32'd1 << (32 - ANGLE_KEEP)) - 1);
        flip = ((p + 32'h4000_0000) & 32'h8000_0000) != 0;
        if (flip) p += 32'h8000_0000;
        z = longint'($signed(p));
        cx = 652032875;
        cy = 0;
        for (int i = 0; i < 24; i++) begin
            dx = asr(cy, i);
            dy = asr(cx, i);
            if (z >= 0) begin
                cx -= dx; cy += dy; z -= atan_tab[i];
            end else begin
                cx += dx; cy -= dy; z += atan_tab[i];
            end
        end
        if (flip) begin
            cx = -cx; cy = -cy;
        end
        mx = $signed(cfg_shadow.pitch_mount_x);
        mz = $signed(cfg_shadow.pitch_mount_z);
        yx = $signed(cfg_shadow.yaw_mount_x);
        yz = $signed(cfg_shadow.yaw_mount_z);
        px = asr(mx * cx - mz * cy + (64'sd1 <<< 29), 30);
        pz = asr(mx * cy + mz * cx + (64'sd1 <<< 29), 30);
        ax = abs64(yx - px);
        az = abs64(yz - pz);
        sh = (ax >= 64'h8000_0000 || az >= 64'h8000_0000) ? 2 : 0;
        ax >>= sh;
        az >>= sh;
        len = int_sqrt(ax * ax + az * az) << sh;
        if (len == 0) return '0;
        m1 = abs64(pz) * abs64(yx);
        s1 = (pz < 0) != (yx < 0);
        m2 = abs64(px) * abs64(yz);
        s2 = !((px < 0) != (yz < 0));
        if (s1 == s2) begin
            tmag = m1 + m2; tneg = s1;
        end else if (m1 >= m2) begin
            tmag = m1 - m2; tneg = s1;
        end else begin
            tmag = m2 - m1; tneg = s2;
        end
        d = longint'(len) - longint'(cfg_shadow.free_length);
        dmag = abs64(d);
        neg = tneg != (d < 0);
        den = len << FRAC;
        num = 128'(tmag) * 128'(dmag) + 128'(den >> 1);
        q = num / 128'(den);
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        if (q == 0) neg = 1'b0;
        t.moment = sat32(neg, q[63:0]);
        mmag = q[63:0];
        if (mmag > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF))
            mmag = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        emag = (mmag * 64'(cfg_shadow.spring_rate) + (64'd1 << (FRAC - 1))) >> FRAC;
        eneg = neg != (cfg_shadow.motor_inverted == 1'b0);
        if (emag == 0) eneg = 1'b0;
        t.effort = sat32(eneg, emag);
        return t;
    endfunction

    // register write while the engine is idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_PITCH_X:   cfg_shadow.pitch_mount_x = val;
            REG_PITCH_Z:   cfg_shadow.pitch_mount_z = val;
            REG_YAW_X:     cfg_shadow.yaw_mount_x = val;
            REG_YAW_Z:     cfg_shadow.yaw_mount_z = val;
            REG_FREE_LEN:  cfg_shadow.free_length = val[30:0];
            REG_RATE:      cfg_shadow.spring_rate = val[30:0];
            REG_MOTOR_INV: cfg_shadow.motor_inverted = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_all(logic [31:0] pxv, logic [31:0] pzv, logic [31:0] yxv,
                             logic [31:0] yzv, logic [31:0] fl, logic [31:0] rate,
                             logic inv);
        write_reg(REG_PITCH_X, pxv);
        write_reg(REG_PITCH_Z, pzv);
        write_reg(REG_YAW_X, yxv);
        write_reg(REG_YAW_Z, yzv);
        write_reg(REG_FREE_LEN, fl);
        write_reg(REG_RATE, rate);
        write_reg(REG_MOTOR_INV, {31'd0, inv});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (torque_q.size() != 0) @(posedge aclk);
        repeat (ENGINE_CYCLES) @(posedge aclk);
    endtask

    // offer one beat, idling first at the current rate
    task automatic send_angle(logic [15:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= angle;
        torque_q.push_back(spring_torque(angle));
        do @(posedge aclk); while (!s_tready);
    endtask

    // random angle, weighted toward quadrant boundaries
    function automatic logic [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(3) * 16'h4000 + $urandom_range(4) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed(32'($urandom_range(6 << 16)) - (3 << 16)));
        endcase
    endfunction

    // cycle limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver ready, with random stalls and a long hold-off
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        torque_t got, exp_t;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (torque_q.size() == 0) begin
                $display("%0t unexpected beat %h", $time, m_tdata);
                err_cnt++;
            end else begin
                exp_t = torque_q.pop_front();
                if (got.effort !== exp_t.effort) begin
                    $display("%0t effort exp %h got %h", $time, exp_t.effort, got.effort);
                    err_cnt++;
                end
                if (got.moment !== exp_t.moment) begin
                    $display("%0t moment exp %h got %h", $time, exp_t.moment, got.moment);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        angle_row_t rows[$];
        angle_row_t r;
        cfg_shadow = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset every length is zero, so results are zero
        rows = '{
            '{16'h0000, 1'b1, '0}, '{16'h7FFF, 1'b1, '0},
            '{16'h8000, 1'b1, '0}, '{16'hFFFF, 1'b1, '0}
        };
        foreach (rows[i]) begin
            send_angle(rows[i].angle);
            if (rows[i].known) torque_q[$] = rows[i].torque;
        end
        drain();

        // realistic geometry, quadrant edges and extremes
        write_all(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0002_0000,
                  32'h0000_4000, 32'h0010_0000, 1'b1);
        rows = '{};
        foreach (rows[i]) ;
        for (int k = 0; k < 12; k++) begin
            r.angle = 16'(k * 16'h2000 + (k[0] ? 1 : 0));
            r.known = 1'b0;
            rows.push_back(r);
        end
        foreach (rows[i]) send_angle(rows[i].angle);
        drain();

        // saturating geometry, max rate, negated effort
        write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        foreach (rows[i]) if (i < 6) send_angle(rows[i].angle);
        drain();

        // zero spring length: pitch and yaw mounts coincide at angle zero
        write_all(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
        send_angle(16'h0000);
        torque_q[$] = '0;
        send_angle(16'h8000);
        drain();

        // random phases with fresh settings
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            write_all(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      ($urandom_range(3) == 0) ? $urandom : $urandom_range(4 << 16),
                      ($urandom_range(3) == 0) ? $urandom : $urandom_range(64 << 16),
                      1'($urandom));
            if (ph == 4) hold_off = 3000;
            for (int n = 0; n < 50; n++) begin
                send_angle(rand_angle());
                // sender pause until everything is back
                if (ph == 6 && n == 25) begin
                    s_tvalid <= 1'b0;
                    while (torque_q.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
